### rtl/clb_pkg.sv
// shared types and constants for the compacting list buffer
// no dependencies; imported by every rtl module and the checker

package clb_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;
  localparam int CMD_W    = 3;
  localparam int POS_W    = 5;
  localparam int STAT_W   = 2;
  localparam int ITEM_W   = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND     = 3'd0,
    CMD_REMOVE_POS = 3'd1,
    CMD_REMOVE_VAL = 3'd2,
    CMD_FIND       = 3'd3,
    CMD_READ       = 3'd4,
    CMD_CLEAR      = 3'd5,
    CMD_COUNT      = 3'd6
  } clb_cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } clb_status_e;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         position;
  } clb_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [POS_W-1:0]         found_position;
    logic signed [WORD_W-1:0] read_value;
    logic [ITEM_W-1:0]        item_count;
  } clb_rsp_t;

  typedef struct packed {
    logic load;
    logic shift;
  } clb_cell_ctrl_t;

endpackage

### rtl/compacting_list_buffer_top.sv
// top level of the compacting list buffer: command sequencer, entry count
// and the chain of clb_cell entries; uses clb_pkg and clb_cell

// A command is captured in S_IDLE; in S_MATCH every cell compares its
// entry with the command's value and the hits are registered; in S_APPLY
// the first hit is picked, the cells from a removed entry upward take
// their upper neighbour's word and the result is written to the output
// register. A new command is taken while a result still waits to be
// collected; the update step of that command then waits until the output
// register is free.

module compacting_list_buffer_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  clb_pkg::clb_req_t req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output clb_pkg::clb_rsp_t rsp_o
);
  import clb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_APPLY
  } state_e;

  state_e                   state_q;
  logic [CMD_W-1:0]         cmd_q;
  logic signed [WORD_W-1:0] value_q;
  logic [POS_W-1:0]         pos_q;
  logic [CNT_W-1:0]         count_q;
  logic [CNT_W-1:0]         count_d;
  logic [CAPACITY-1:0]      match_q;
  logic                     out_valid_q;
  clb_rsp_t                 rsp_q;
  clb_rsp_t                 rsp_d;

  logic signed [WORD_W-1:0] word   [CAPACITY];
  logic [CAPACITY-1:0]      hit_raw;
  clb_cell_ctrl_t           ctrl   [CAPACITY];

  logic                     out_free;
  logic                     apply;
  logic                     load_en;
  logic                     shift_en;
  logic [CNT_W-1:0]         shift_from;
  logic [IDX_W-1:0]         first_idx;
  logic signed [WORD_W-1:0] rd_word;
  logic                     pos_ok;

  assign out_free    = !out_valid_q || out_ready_i;
  assign apply       = (state_q == S_APPLY) && out_free;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [WORD_W-1:0] next_word;
    if (i == CAPACITY - 1) begin : g_last
      assign next_word = word[i];
    end else begin : g_mid
      assign next_word = word[i+1];
    end

    assign ctrl[i].load  = apply && load_en && (CNT_W'(i) == count_q);
    assign ctrl[i].shift = apply && shift_en && (CNT_W'(i) >= shift_from);

    clb_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[i]),
      .value_i (value_q),
      .next_i  (next_word),
      .word_o  (word[i]),
      .match_o (hit_raw[i])
    );
  end

  always_comb begin
    first_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        first_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (int'(pos_q) == i) begin
        rd_word = word[i];
      end
    end
  end

  assign pos_ok = (int'(pos_q) < int'(count_q)) && (int'(pos_q) < CAPACITY);

  always_comb begin
    rsp_d      = '0;
    count_d    = count_q;
    load_en    = 1'b0;
    shift_en   = 1'b0;
    shift_from = '0;
    unique case (cmd_q)
      CMD_APPEND: begin
        if (int'(count_q) >= CAPACITY) begin
          rsp_d.status = ST_FULL;
        end else begin
          load_en = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      CMD_REMOVE_POS: begin
        if (!pos_ok) begin
          rsp_d.status = ST_RANGE;
        end else begin
          shift_en   = 1'b1;
          shift_from = CNT_W'(pos_q);
          count_d    = count_q - CNT_W'(1);
        end
      end
      CMD_REMOVE_VAL: begin
        if (|match_q) begin
          rsp_d.found_position = POS_W'(first_idx);
          shift_en             = 1'b1;
          shift_from           = CNT_W'(first_idx);
          count_d              = count_q - CNT_W'(1);
        end else begin
          rsp_d.status = ST_NOT_FOUND;
        end
      end
      CMD_FIND: begin
        if (|match_q) begin
          rsp_d.found_position = POS_W'(first_idx);
        end else begin
          rsp_d.status = ST_NOT_FOUND;
        end
      end
      CMD_READ: begin
        if (pos_ok) begin
          rsp_d.read_value = rd_word;
        end else begin
          rsp_d.status = ST_RANGE;
        end
      end
      CMD_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
    rsp_d.item_count = ITEM_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      cmd_q       <= '0;
      value_q     <= '0;
      pos_q       <= '0;
      match_q     <= '0;
      rsp_q       <= '0;
    end else begin
      if (apply) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q   <= req_i.command;
            value_q <= req_i.value;
            pos_q   <= req_i.position;
            state_q <= S_MATCH;
          end
        end
        S_MATCH: begin
          for (int i = 0; i < CAPACITY; i++) begin
            match_q[i] <= hit_raw[i] && (i < int'(count_q));
          end
          state_q <= S_APPLY;
        end
        S_APPLY: begin
          if (out_free) begin
            count_q <= count_d;
            rsp_q   <= rsp_d;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/clb_cell.sv
// one list entry: holds a word, loads the command value, compares it with
// the search key and takes its upper neighbour's word on a shift; uses clb_pkg

module clb_cell (
  input  logic                          clk_i,
  input  clb_pkg::clb_cell_ctrl_t       ctrl_i,
  input  logic signed [clb_pkg::WORD_W-1:0] value_i,
  input  logic signed [clb_pkg::WORD_W-1:0] next_i,
  output logic signed [clb_pkg::WORD_W-1:0] word_o,
  output logic                          match_o
);
  import clb_pkg::*;

  logic signed [WORD_W-1:0] word_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      word_q <= next_i;
    end else if (ctrl_i.load) begin
      word_q <= value_i;
    end
  end

  assign word_o  = word_q;
  assign match_o = (word_q == value_i);

endmodule

### rtl/clb_checker.sv
// port-level checks for the compacting list buffer, bound to the top level
// uses clb_pkg; watches compacting_list_buffer_top ports only

module clb_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input clb_pkg::clb_rsp_t rsp_o
);
  import clb_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rsp_o))
    else $error("result dropped or changed while stalled");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(rsp_o.item_count) <= CAPACITY)
    else $error("item count above capacity");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (rsp_o.status == ST_FULL) |-> int'(rsp_o.item_count) == CAPACITY)
    else $error("full status while not full");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (rsp_o.status != ST_OK)
      |-> (rsp_o.read_value == '0) && (rsp_o.found_position == '0))
    else $error("refused transfer carries data");

endmodule

bind compacting_list_buffer_top clb_checker u_clb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .rsp_o       (rsp_o)
);

### tb/testbench.sv
// self-checking testbench for compacting_list_buffer_top: random and directed list commands,
// predicted in a behavioural list model and checked against every response transfer
// depends on clb_pkg and the rtl of the compacting list buffer

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import clb_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;
  localparam int IDLE_PCT  = 19;
  localparam int HOLD_LEN  = 80;
  localparam int HOLD_AT   = 300;
  localparam int WD_LIMIT  = 1000;
  localparam int DRAIN_LAT = 12;
  localparam int PRINT_MAX = 30;

  logic     clk_i;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  logic     out_ready = 1'b0;
  clb_req_t req       = '0;
  logic     in_ready;
  logic     out_valid;
  clb_rsp_t rsp;

  compacting_list_buffer_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .req_i       (req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .rsp_o       (rsp)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // list model
  logic signed [WORD_W-1:0] list_words [CAPACITY];
  int unsigned              list_len = 0;

  clb_req_t pending [$];
  clb_rsp_t expected [$];
  clb_rsp_t staged_rsp = '0;
  logic     staged_v   = 1'b0;

  int sent       = 0;
  int checked    = 0;
  int errors     = 0;
  int full_hits  = 0;
  int range_hits = 0;
  int miss_hits  = 0;
  int idle_run   = 0;
  int hold_left  = 0;
  logic held     = 1'b0;

  logic signed [WORD_W-1:0] value_pool [8];

  task automatic report_error(input string msg);
    if (errors < PRINT_MAX) $display("error: %s", msg);
    errors++;
  endtask

  function automatic clb_rsp_t apply_command(input clb_req_t rq);
    clb_rsp_t r;
    int       hit;
    int       drop;
    int       i;
    r    = '0;
    hit  = -1;
    drop = -1;
    r.status = ST_OK;
    case (rq.command) inside
      CMD_APPEND: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          list_words[IDX_W'(list_len)] = rq.value;
          list_len++;
        end
      end
      CMD_REMOVE_POS, CMD_READ: begin
        if (rq.position >= list_len) begin
          r.status = ST_RANGE;
        end else if (rq.command == CMD_READ) begin
          r.read_value = list_words[rq.position];
        end else begin
          drop = int'(rq.position);
        end
      end
      CMD_REMOVE_VAL, CMD_FIND: begin
        for (i = 0; i < list_len; i++)
          if (hit < 0 && list_words[IDX_W'(i)] == rq.value) hit = i;
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.found_position = POS_W'(hit);
          if (rq.command == CMD_REMOVE_VAL) drop = hit;
        end
      end
      CMD_CLEAR: list_len = 0;
      default: ;
    endcase
    if (drop >= 0) begin
      for (i = drop; i + 1 < list_len; i++)
        list_words[IDX_W'(i)] = list_words[IDX_W'(i + 1)];
      list_len--;
    end
    r.item_count = ITEM_W'(list_len);
    if (r.status == ST_FULL) full_hits++;
    if (r.status == ST_RANGE) range_hits++;
    if (r.status == ST_NOT_FOUND) miss_hits++;
    return r;
  endfunction

  task automatic offer(input logic [CMD_W-1:0] cmd, input logic signed [WORD_W-1:0] val,
                       input logic [POS_W-1:0] pos);
    clb_req_t rq;
    rq.command  = cmd;
    rq.value    = val;
    rq.position = pos;
    pending.push_back(rq);
  endtask

  function automatic logic signed [WORD_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 60) return value_pool[3'($urandom_range(7))];
    if (r < 70) return value_pool[3'($urandom_range(3))];
    return $urandom;
  endfunction

  // mode 0 grows the list, 1 is mixed, 2 shrinks it, 3 appends only
  function automatic logic [CMD_W-1:0] pick_command(input int mode);
    int r;
    int k;
    int app;
    app = (mode == 3) ? 100 : (mode == 0) ? 55 : (mode == 1) ? 35 : 12;
    r = $urandom_range(99);
    if (r < app) return CMD_APPEND;
    k = $urandom_range(19);
    if (k < 4) return CMD_REMOVE_POS;
    if (k < 8) return CMD_REMOVE_VAL;
    if (k < 12) return CMD_FIND;
    if (k < 17) return CMD_READ;
    if (k == 17) return CMD_COUNT;
    if (k == 18) return CMD_SPARE;
    return ($urandom_range(3) == 0) ? CMD_CLEAR : CMD_READ;
  endfunction

  task automatic queue_random(input int n, input logic fill_first);
    int idx;
    int mode;
    for (idx = 0; idx < n; idx++) begin
      mode = (fill_first && idx < 40) ? 3 : (idx / 60) % 3;
      offer(pick_command(mode), pick_value(), POS_W'($urandom_range(31)));
    end
  endtask

  task automatic wait_drained();
    while (pending.size() != 0 || in_valid || staged_v || expected.size() != 0)
      @(negedge clk_i);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      staged_v <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        staged_rsp <= apply_command(req);
        staged_v   <= 1'b1;
        sent++;
      end else begin
        staged_v <= 1'b0;
      end
      if (!in_valid || in_ready) begin
        if (pending.size() != 0 &&
            ((sent >= 700 && sent < 900) || $urandom_range(99) >= IDLE_PCT)) begin
          req      <= pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    clb_rsp_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (staged_v) expected.push_back(staged_rsp);
      if (out_valid && out_ready) begin
        if (expected.size() == 0) begin
          report_error($sformatf("response transfer %0d with nothing outstanding", checked));
        end else begin
          want = expected.pop_front();
          if (rsp.status !== want.status)
            report_error($sformatf("result %0d status %0d, want %0d",
                                   checked, rsp.status, want.status));
          if (rsp.found_position !== want.found_position)
            report_error($sformatf("result %0d found_position %0d, want %0d",
                                   checked, rsp.found_position, want.found_position));
          if (rsp.read_value !== want.read_value)
            report_error($sformatf("result %0d read_value %h, want %h",
                                   checked, rsp.read_value, want.read_value));
          if (rsp.item_count !== want.item_count)
            report_error($sformatf("result %0d item_count %0d, want %0d",
                                   checked, rsp.item_count, want.item_count));
        end
        checked++;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else if (!held && checked >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_LEN;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (checked >= 750 && checked < 950) || $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_run = 0;
      end else begin
        idle_run++;
        if (idle_run >= WD_LIMIT) begin
          $display("timeout after %0d cycles without a transfer", idle_run);
          $display("testbench: done, errors");
          $finish;
        end
      end
    end
  end

  initial begin
    value_pool[0] = '0;
    value_pool[1] = -1;
    value_pool[2] = 32'sh7fffffff;
    value_pool[3] = 32'sh80000000;
    value_pool[4] = $urandom;
    value_pool[5] = $urandom;
    value_pool[6] = $urandom;
    value_pool[7] = $urandom;

    // empty list corner cases, then a short list exercised end to end
    offer(CMD_COUNT, '0, '0);
    offer(CMD_READ, '0, '0);
    offer(CMD_REMOVE_POS, '0, '0);
    offer(CMD_FIND, value_pool[1], '0);
    offer(CMD_REMOVE_VAL, value_pool[0], '0);
    offer(CMD_APPEND, value_pool[3], '0);
    offer(CMD_APPEND, value_pool[2], '1);
    offer(CMD_APPEND, value_pool[0], '0);
    offer(CMD_APPEND, value_pool[1], '1);
    offer(CMD_APPEND, value_pool[2], '0);
    offer(CMD_FIND, value_pool[2], '0);
    offer(CMD_FIND, value_pool[1], '1);
    offer(CMD_FIND, value_pool[4], '0);
    offer(CMD_READ, '1, '0);
    offer(CMD_READ, '0, 5'd4);
    offer(CMD_READ, '0, 5'd5);
    offer(CMD_READ, '0, '1);
    offer(CMD_REMOVE_VAL, value_pool[2], '0);
    offer(CMD_READ, '0, 5'd1);
    offer(CMD_REMOVE_POS, '0, '1);
    offer(CMD_REMOVE_POS, '0, '0);
    offer(CMD_REMOVE_POS, '0, 5'd2);
    offer(CMD_SPARE, '1, '1);
    offer(CMD_CLEAR, '1, '1);
    offer(CMD_COUNT, '1, '1);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait_drained();
    queue_random(650, 1'b1);
    wait_drained();
    queue_random(675, 1'b0);
    wait_drained();
    repeat (DRAIN_LAT) @(negedge clk_i);

    $display("summary: %0d commands, %0d responses checked, %0d errors", sent, checked, errors);
    $display("summary: %0d full refusals, %0d range refusals, %0d misses",
             full_hits, range_hits, miss_hits);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
